### rtl/nmeap_pkg.sv
// ----------------------------------------------------------------------------
// nmeap_pkg: shared types and constants of the NMEA position sentence parser
// Sentence formats, field roles, character codes, result codes and limits.
// ----------------------------------------------------------------------------
package nmeap_pkg;

	// Sentence formats carried with every character.
	localparam logic [1:0] CMD_RMC = 2'd0;
	localparam logic [1:0] CMD_GLL = 2'd1;
	localparam logic [1:0] CMD_GGA = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_VALID   = 2'd0;
	localparam logic [1:0] ST_TOO_FEW = 2'd1;
	localparam logic [1:0] ST_NO_FIX  = 2'd2;

	// Characters that steer the parse.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_W     = 8'h57;

	// Limits.
	localparam logic [3:0]  FIELD_CAP  = 4'd15;
	localparam logic [3:0]  MIN_FIELDS = 4'd7;
	localparam logic [7:0]  LEN_CAP    = 8'd255;
	localparam logic [9:0]  DEG_SAT    = 10'd1023;
	localparam logic [31:0] MIN_SAT    = 32'hFFFF_FFFF;
	localparam logic [26:0] SPEED_SAT  = 27'd99999999;
	localparam logic [35:0] POS_SAT    = 36'd2147483647;

	// Coordinate digit phases.
	localparam logic [3:0] CP_DEG     = 4'd0;
	localparam logic [3:0] CP_DEG_END = 4'd1;
	localparam logic [3:0] CP_MIN_INT = 4'd2;
	localparam logic [3:0] CP_FRAC1   = 4'd3;
	localparam logic [3:0] CP_FRAC5   = 4'd7;
	localparam logic [3:0] CP_DONE    = 4'd8;

	// Speed digit phases.
	localparam logic [2:0] SP_INT  = 3'd0;
	localparam logic [2:0] SP_FRAC = 3'd1;
	localparam logic [2:0] SP_DONE = 3'd4;

	// Quality digit phases.
	localparam logic [1:0] QP_LEAD  = 2'd0;
	localparam logic [1:0] QP_DIGIT = 2'd1;
	localparam logic [1:0] QP_DONE  = 2'd2;

	typedef enum logic [2:0] {
		ROLE_NONE,
		ROLE_LAT,
		ROLE_LATH,
		ROLE_LON,
		ROLE_LONH,
		ROLE_STATUS,
		ROLE_QUAL,
		ROLE_SPEED
	} nmeap_role_t;

	typedef struct packed {
		logic        use_val;
		logic        neg;
		logic [9:0]  deg;
		logic [31:0] min;
	} nmeap_coord_t;

	typedef struct packed {
		logic [1:0]   status;
		logic         fix;
		logic [26:0]  speed;
		nmeap_coord_t lat;
		nmeap_coord_t lon;
	} nmeap_verdict_t;

	// Role of a field, by format and field number.
	function automatic nmeap_role_t role_of(input logic [1:0] cmd, input logic [3:0] tok);
		nmeap_role_t r;
		r = ROLE_NONE;
		if (tok < 4'd8) begin
			case (cmd)
				CMD_RMC: begin
					case (tok[2:0])
						3'd2: r = ROLE_STATUS;
						3'd3: r = ROLE_LAT;
						3'd4: r = ROLE_LATH;
						3'd5: r = ROLE_LON;
						3'd6: r = ROLE_LONH;
						3'd7: r = ROLE_SPEED;
						default: r = ROLE_NONE;
					endcase
				end
				CMD_GLL: begin
					case (tok[2:0])
						3'd1: r = ROLE_LAT;
						3'd2: r = ROLE_LATH;
						3'd3: r = ROLE_LON;
						3'd4: r = ROLE_LONH;
						3'd6: r = ROLE_STATUS;
						default: r = ROLE_NONE;
					endcase
				end
				CMD_GGA: begin
					case (tok[2:0])
						3'd2: r = ROLE_LAT;
						3'd3: r = ROLE_LATH;
						3'd4: r = ROLE_LON;
						3'd5: r = ROLE_LONH;
						3'd6: r = ROLE_QUAL;
						default: r = ROLE_NONE;
					endcase
				end
				default: r = ROLE_NONE;
			endcase
		end
		return r;
	endfunction

	// Weight of the next minute fraction digit (1e-5 minute units).
	function automatic logic [13:0] frac_weight(input logic [3:0] ph);
		logic [13:0] w;
		case (ph)
			4'd3:    w = 14'd10000;
			4'd4:    w = 14'd1000;
			4'd5:    w = 14'd100;
			4'd6:    w = 14'd10;
			default: w = 14'd1;
		endcase
		return w;
	endfunction

	// Weight of the next speed fraction digit (thousandths of a knot).
	function automatic logic [6:0] speed_weight(input logic [2:0] ph);
		logic [6:0] w;
		case (ph)
			3'd1:    w = 7'd100;
			3'd2:    w = 7'd10;
			default: w = 7'd1;
		endcase
		return w;
	endfunction

endpackage

### rtl/nmeap_char_if.sv
// ----------------------------------------------------------------------------
// nmeap_char_if: character channel of the sentence parser
// Valid/ready channel carrying one sentence character with format and end mark.
// ----------------------------------------------------------------------------
interface nmeap_char_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] char_byte;
	logic       last;

	modport source(output valid, output cmd, output char_byte, output last, input ready);
	modport sink(input valid, input cmd, input char_byte, input last, output ready);
endinterface

### rtl/nmeap_result_if.sv
// ----------------------------------------------------------------------------
// nmeap_result_if: result channel of the sentence parser
// Valid/ready channel carrying one parsed position report.
// ----------------------------------------------------------------------------
interface nmeap_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic               fix_active;
	logic signed [31:0] latitude;
	logic signed [31:0] longitude;
	logic [26:0]        speed_milliknots;

	modport source(output valid, output status, output fix_active, output latitude,
		output longitude, output speed_milliknots, input ready);
	modport sink(input valid, input status, input fix_active, input latitude,
		input longitude, input speed_milliknots, output ready);
endinterface

### rtl/nmeap_tokenizer.sv
// ----------------------------------------------------------------------------
// nmeap_tokenizer: per-character field splitting and number accumulation
// Updates the sentence state for each character and captures a verdict on last.
// ----------------------------------------------------------------------------
module nmeap_tokenizer import nmeap_pkg::*; #(
	parameter int LINE_LEN = 128
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  logic [1:0]     cmd,
	input  logic [7:0]     char_byte,
	input  logic           last,
	output nmeap_verdict_t verdict_s2
);

	localparam int CW = $clog2(LINE_LEN);
	localparam logic [CW-1:0] LAST_POS = CW'(LINE_LEN - 1);

	logic [CW-1:0] cc_q, cc_n;
	logic [3:0]    fi_q, fi_n;
	logic [7:0]    flen_q, flen_n;
	logic [9:0]    deg_q [4];
	logic [9:0]    deg_n [4];
	logic [31:0]   min_q [4];
	logic [31:0]   min_n [4];
	logic [3:0]    ph_q [4];
	logic [3:0]    ph_n [4];
	logic [1:0]    clok_q, clok_n;
	logic [7:0]    hem_q [2];
	logic [7:0]    hem_n [2];
	logic          sta_q, sta_n;
	logic          qnz_q, qnz_n;
	logic [1:0]    qph_q, qph_n;
	logic [26:0]   spd_q, spd_n;
	logic [2:0]    sph_q, sph_n;
	logic          fix_held_q, fix_held_n;
	nmeap_verdict_t verdict;

	always_comb begin
		logic        digit;
		logic [3:0]  dval;
		logic [7:0]  p;
		nmeap_role_t role;
		logic        kk;
		logic [1:0]  idx;
		logic [3:0]  phc;
		logic [35:0] mv;
		logic [30:0] sv;
		logic [13:0] dv;
		logic        counted;
		logic        fix;
		logic        sel;
		logic [1:0]  ci;
		cc_n   = cc_q;
		fi_n   = fi_q;
		flen_n = flen_q;
		deg_n  = deg_q;
		min_n  = min_q;
		ph_n   = ph_q;
		clok_n = clok_q;
		hem_n  = hem_q;
		sta_n  = sta_q;
		qnz_n  = qnz_q;
		qph_n  = qph_q;
		spd_n  = spd_q;
		sph_n  = sph_q;
		digit  = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
		dval   = char_byte[3:0];
		p      = flen_q;
		role   = ROLE_NONE;
		kk     = 1'b0;
		idx    = 2'd0;
		phc    = CP_DEG;
		mv     = '0;
		sv     = '0;
		dv     = '0;
		if (cc_q < LAST_POS) begin
			if (char_byte == CH_NUL) begin
				cc_n = LAST_POS;
			end else begin
				cc_n = cc_q + 1'b1;
				if (char_byte == CH_COMMA) begin
					flen_n = '0;
				end else begin
					if (flen_q == 8'd0 && fi_q < FIELD_CAP) fi_n = fi_q + 1'b1;
					if (flen_q != LEN_CAP) flen_n = flen_q + 1'b1;
					role = role_of(cmd, fi_n - 4'd1);
					case (role)
						ROLE_LAT, ROLE_LON: begin
							kk = (role == ROLE_LON);
							clok_n[kk] = (p >= 8'd3);
							for (int s = 0; s < 2; s++) begin
								idx = {kk, 1'(s)};
								if (p < 8'(2 + s)) begin
									if (ph_q[idx] == CP_DEG) begin
										if (digit) begin
											dv = 14'(deg_q[idx]) * 14'd10 + 14'(dval);
											deg_n[idx] = (dv > 14'(DEG_SAT)) ? DEG_SAT : dv[9:0];
										end else begin
											ph_n[idx] = CP_DEG_END;
										end
									end
								end else begin
									phc = (p == 8'(2 + s)) ? CP_MIN_INT : ph_q[idx];
									ph_n[idx] = phc;
									if (phc == CP_MIN_INT) begin
										if (digit) begin
											mv = {min_q[idx], 3'b0} + {3'b0, min_q[idx], 1'b0}
												+ 36'(dval) * 36'd100000;
											min_n[idx] = (mv > 36'(MIN_SAT)) ? MIN_SAT : mv[31:0];
										end else if (char_byte == CH_DOT) begin
											ph_n[idx] = CP_FRAC1;
										end else begin
											ph_n[idx] = CP_DONE;
										end
									end else if (phc >= CP_FRAC1 && phc <= CP_FRAC5) begin
										if (digit) begin
											mv = 36'(min_q[idx]) + 36'(dval) * 36'(frac_weight(phc));
											min_n[idx] = (mv > 36'(MIN_SAT)) ? MIN_SAT : mv[31:0];
											ph_n[idx] = phc + 1'b1;
										end else begin
											ph_n[idx] = CP_DONE;
										end
									end
								end
							end
						end
						ROLE_LATH: if (p == 8'd0) hem_n[0] = char_byte;
						ROLE_LONH: if (p == 8'd0) hem_n[1] = char_byte;
						ROLE_STATUS: if (p == 8'd0) sta_n = (char_byte == CH_A);
						ROLE_QUAL: begin
							if (qph_q == QP_LEAD) begin
								if (char_byte == CH_SPACE || (char_byte >= CH_TAB && char_byte <= CH_CR)) begin
									qph_n = QP_LEAD;
								end else if (char_byte == CH_PLUS || char_byte == CH_MINUS) begin
									qph_n = QP_DIGIT;
								end else if (digit) begin
									qph_n = QP_DIGIT;
									if (char_byte != CH_ZERO) qnz_n = 1'b1;
								end else begin
									qph_n = QP_DONE;
								end
							end else if (qph_q == QP_DIGIT) begin
								if (digit) begin
									if (char_byte != CH_ZERO) qnz_n = 1'b1;
								end else begin
									qph_n = QP_DONE;
								end
							end
						end
						ROLE_SPEED: begin
							if (sph_q == SP_INT) begin
								if (digit) begin
									sv = {spd_q, 3'b0} + {3'b0, spd_q, 1'b0} + 31'(dval) * 31'd1000;
									spd_n = (sv > 31'(SPEED_SAT)) ? SPEED_SAT : sv[26:0];
								end else if (char_byte == CH_DOT) begin
									sph_n = SP_FRAC;
								end else begin
									sph_n = SP_DONE;
								end
							end else if (sph_q < SP_DONE) begin
								if (digit) begin
									sv = 31'(spd_q) + 31'(dval) * 31'(speed_weight(sph_q));
									spd_n = (sv > 31'(SPEED_SAT)) ? SPEED_SAT : sv[26:0];
									sph_n = sph_q + 1'b1;
								end else begin
									sph_n = SP_DONE;
								end
							end
						end
						default: ;
					endcase
				end
			end
		end

		// Verdict on the state as it stands after this character.
		counted = (cmd != 2'd3) && (fi_n >= MIN_FIELDS);
		fix     = (cmd == CMD_GGA) ? qnz_n : sta_n;
		if (!counted)  verdict.status = ST_TOO_FEW;
		else if (!fix) verdict.status = ST_NO_FIX;
		else           verdict.status = ST_VALID;
		fix_held_n  = counted ? fix : fix_held_q;
		verdict.fix = fix_held_n;
		verdict.speed = (verdict.status == ST_VALID && cmd == CMD_RMC) ? spd_n : '0;
		sel = !(hem_n[0] == CH_N || hem_n[0] == CH_S);
		ci  = {1'b0, sel};
		verdict.lat.use_val = (verdict.status == ST_VALID) && clok_n[0];
		verdict.lat.neg     = (hem_n[0] == CH_S) || (hem_n[0] == CH_W);
		verdict.lat.deg     = deg_n[ci];
		verdict.lat.min     = min_n[ci];
		sel = !(hem_n[1] == CH_N || hem_n[1] == CH_S);
		ci  = {1'b1, sel};
		verdict.lon.use_val = (verdict.status == ST_VALID) && clok_n[1];
		verdict.lon.neg     = (hem_n[1] == CH_S) || (hem_n[1] == CH_W);
		verdict.lon.deg     = deg_n[ci];
		verdict.lon.min     = min_n[ci];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q       <= '0;
			fi_q       <= '0;
			flen_q     <= '0;
			deg_q      <= '{default: '0};
			min_q      <= '{default: '0};
			ph_q       <= '{default: CP_DEG};
			clok_q     <= '0;
			hem_q      <= '{default: '0};
			sta_q      <= 1'b0;
			qnz_q      <= 1'b0;
			qph_q      <= QP_LEAD;
			spd_q      <= '0;
			sph_q      <= SP_INT;
			fix_held_q <= 1'b0;
		end else if (go) begin
			if (last) begin
				cc_q       <= '0;
				fi_q       <= '0;
				flen_q     <= '0;
				deg_q      <= '{default: '0};
				min_q      <= '{default: '0};
				ph_q       <= '{default: CP_DEG};
				clok_q     <= '0;
				hem_q      <= '{default: '0};
				sta_q      <= 1'b0;
				qnz_q      <= 1'b0;
				qph_q      <= QP_LEAD;
				spd_q      <= '0;
				sph_q      <= SP_INT;
				fix_held_q <= fix_held_n;
			end else begin
				cc_q   <= cc_n;
				fi_q   <= fi_n;
				flen_q <= flen_n;
				deg_q  <= deg_n;
				min_q  <= min_n;
				ph_q   <= ph_n;
				clok_q <= clok_n;
				hem_q  <= hem_n;
				sta_q  <= sta_n;
				qnz_q  <= qnz_n;
				qph_q  <= qph_n;
				spd_q  <= spd_n;
				sph_q  <= sph_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && last) verdict_s2 <= verdict;
	end

endmodule

### rtl/nmeap_coord_conv.sv
// ----------------------------------------------------------------------------
// nmeap_coord_conv: degrees and minutes to signed 1e-7 degree units
// Three register stages: scale, divide by three, then sum, saturate and sign.
// ----------------------------------------------------------------------------
module nmeap_coord_conv import nmeap_pkg::*; (
	input  logic               clk,
	input  logic               en_s3,
	input  logic               en_s4,
	input  logic               en_out,
	input  nmeap_coord_t       coord,
	output logic signed [31:0] value_q
);

	// minutes are in 1e-5 units, so min*100/60 rounds as (5*min+1)/3.
	logic [35:0] x_s3, qb_s3, x_s4, qe_s4;
	logic [33:0] dm_s3, dm_s4;
	logic        use_s3, neg_s3, use_s4, neg_s4;

	always_ff @(posedge clk) begin
		logic [35:0] x, qa;
		x  = {coord.min, 2'b0} + 36'(coord.min) + 36'd1;
		qa = (x >> 2) + (x >> 4);
		if (en_s3) begin
			x_s3   <= x;
			qb_s3  <= qa + (qa >> 4);
			dm_s3  <= 34'(coord.deg) * 34'd10000000;
			use_s3 <= coord.use_val;
			neg_s3 <= coord.neg;
		end
	end

	always_ff @(posedge clk) begin
		logic [35:0] qc, qd;
		qc = qb_s3 + (qb_s3 >> 8);
		qd = qc + (qc >> 16);
		if (en_s4) begin
			x_s4   <= x_s3;
			qe_s4  <= qd + (qd >> 32);
			dm_s4  <= dm_s3;
			use_s4 <= use_s3;
			neg_s4 <= neg_s3;
		end
	end

	always_ff @(posedge clk) begin
		logic [35:0] r, qf, mag;
		logic [39:0] r11;
		r   = x_s4 - (qe_s4 + {qe_s4[34:0], 1'b0});
		r11 = {r, 3'b0} + {3'b0, r, 1'b0} + 40'(r);
		qf  = qe_s4 + 36'(r11 >> 5);
		mag = 36'(dm_s4) + qf;
		if (mag > POS_SAT) mag = POS_SAT;
		if (en_out) begin
			if (!use_s4)     value_q <= '0;
			else if (neg_s4) value_q <= -$signed(mag[31:0]);
			else             value_q <= $signed(mag[31:0]);
		end
	end

endmodule

### rtl/nmeap_dummy_placeholder.sv
// ----------------------------------------------------------------------------
// nmeap_out_stage: result output register with side fields
// Carries status, fix and speed alongside the coordinate pipeline.
// ----------------------------------------------------------------------------
module nmeap_out_stage import nmeap_pkg::*; (
	input  logic        clk,
	input  logic        en_s3,
	input  logic        en_s4,
	input  logic        en_out,
	input  logic [1:0]  status,
	input  logic        fix,
	input  logic [26:0] speed,
	output logic [1:0]  status_q,
	output logic        fix_q,
	output logic [26:0] speed_q
);

	logic [1:0]  status_s3, status_s4;
	logic        fix_s3, fix_s4;
	logic [26:0] speed_s3, speed_s4;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			status_s3 <= status;
			fix_s3    <= fix;
			speed_s3  <= speed;
		end
		if (en_s4) begin
			status_s4 <= status_s3;
			fix_s4    <= fix_s3;
			speed_s4  <= speed_s3;
		end
		if (en_out) begin
			status_q <= status_s4;
			fix_q    <= fix_s4;
			speed_q  <= (speed_s4 > SPEED_SAT) ? SPEED_SAT : speed_s4;
		end
	end

endmodule

### rtl/nmeap_coord_conv_top_unused.sv
// ----------------------------------------------------------------------------
// nmeap_ctrl: stage valid tracking for the result pipeline
// Holds the valid bit of every stage and derives per-stage load enables.
// ----------------------------------------------------------------------------
module nmeap_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	input  logic out_ready,
	output logic in_ready,
	output logic go,
	output logic load_s1,
	output logic en_s3,
	output logic en_s4,
	output logic en_out,
	output logic out_valid
);

	logic v_s1_q, v_s2_q, v_s3_q, v_s4_q, v_out_q;
	logic rdy_out, rdy_s4, rdy_s3, rdy_s2;

	assign rdy_out   = !v_out_q || out_ready;
	assign rdy_s4    = !v_s4_q || rdy_out;
	assign rdy_s3    = !v_s3_q || rdy_s4;
	assign rdy_s2    = !v_s2_q || rdy_s3;
	assign go        = v_s1_q && (!in_last || rdy_s2);
	assign in_ready  = !v_s1_q || go;
	assign load_s1   = in_valid && in_ready;
	assign en_s3     = rdy_s3 && v_s2_q;
	assign en_s4     = rdy_s4 && v_s3_q;
	assign en_out    = rdy_out && v_s4_q;
	assign out_valid = v_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q  <= 1'b0;
			v_s2_q  <= 1'b0;
			v_s3_q  <= 1'b0;
			v_s4_q  <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (load_s1) v_s1_q <= 1'b1;
			else if (go) v_s1_q <= 1'b0;
			if (rdy_s2)  v_s2_q  <= go && in_last;
			if (rdy_s3)  v_s3_q  <= v_s2_q;
			if (rdy_s4)  v_s4_q  <= v_s3_q;
			if (rdy_out) v_out_q <= v_s4_q;
		end
	end

endmodule

### rtl/nmea_position_sentence_parser.sv
// ----------------------------------------------------------------------------
// nmea_position_sentence_parser: RMC, GLL and GGA position sentence parser
// Throughput: one character per clock; a character that ends a sentence
// waits while the verdict register is full and cannot pass its verdict on.
// Path: input register, verdict register, then three conversion stages.
// Reset: arst_n clears all sentence state, the held fix (void) and stage valids.
// ----------------------------------------------------------------------------
module nmea_position_sentence_parser import nmeap_pkg::*; #(
	parameter int LINE_LEN = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	nmeap_char_if.sink      chars,
	nmeap_result_if.source  result
);

	// Input register. A character sits here while its state update is done;
	// it only waits when it ends a sentence and the verdict slot is still full.
	logic [1:0] cmd_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	logic go, load_s1, en_s3, en_s4, en_out;
	nmeap_verdict_t verdict_s2;

	nmeap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chars.valid),
		.in_last   (last_s1),
		.out_ready (result.ready),
		.in_ready  (chars.ready),
		.go        (go),
		.load_s1   (load_s1),
		.en_s3     (en_s3),
		.en_s4     (en_s4),
		.en_out    (en_out),
		.out_valid (result.valid)
	);

	always_ff @(posedge clk) begin
		if (load_s1) begin
			cmd_s1  <= chars.cmd;
			char_s1 <= chars.char_byte;
			last_s1 <= chars.last;
		end
	end

	// Field splitting, digit accumulation and the verdict on the last character.
	nmeap_tokenizer #(.LINE_LEN(LINE_LEN)) u_tok (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.cmd        (cmd_s1),
		.char_byte  (char_s1),
		.last       (last_s1),
		.verdict_s2 (verdict_s2)
	);

	// The two coordinates convert side by side in identical pipelines.
	nmeap_coord_conv u_lat (
		.clk     (clk),
		.en_s3   (en_s3),
		.en_s4   (en_s4),
		.en_out  (en_out),
		.coord   (verdict_s2.lat),
		.value_q (result.latitude)
	);

	nmeap_coord_conv u_lon (
		.clk     (clk),
		.en_s3   (en_s3),
		.en_s4   (en_s4),
		.en_out  (en_out),
		.coord   (verdict_s2.lon),
		.value_q (result.longitude)
	);

	// Status, fix and speed ride along with the coordinate stages.
	nmeap_out_stage u_side (
		.clk      (clk),
		.en_s3    (en_s3),
		.en_s4    (en_s4),
		.en_out   (en_out),
		.status   (verdict_s2.status),
		.fix      (verdict_s2.fix),
		.speed    (verdict_s2.speed),
		.status_q (result.status),
		.fix_q    (result.fix_active),
		.speed_q  (result.speed_milliknots)
	);

`ifndef SYNTHESIS
	// A report that is not a valid position carries no coordinates or speed.
	a_zero_unless_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status != ST_VALID) |->
		(result.latitude == 32'sd0 && result.longitude == 32'sd0
			&& result.speed_milliknots == 27'd0))
		else $error("non-valid report carries position data");

	// The held fix agrees with the verdict it was updated from.
	a_fix_follows_status: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status == ST_VALID) |-> result.fix_active)
		else $error("valid position without active fix");

	a_nofix_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status == ST_NO_FIX) |-> !result.fix_active)
		else $error("no-fix report with active fix");

	// A character that does not end a sentence never waits in the input register.
	a_char_not_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(!chars.ready) |-> last_s1)
		else $error("input stalled on a mid-sentence character");
`endif

endmodule

### tb/tb_nmea_position_sentence_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nmea_position_sentence_parser: self-checking bench for the sentence parser
// Feeds RMC, GLL and GGA sentences, both well formed and mangled, one character
// per request, predicts each position report and compares it with the block.
// ----------------------------------------------------------------------------
module tb_nmea_position_sentence_parser;
	import nmeap_pkg::*;

	localparam int LINE_LEN = 128;
	localparam int CHAR_GOAL = 1950;
	localparam int IDLE_LIMIT = 5000;

	// One character request as it waits in the stimulus queue. A held request
	// is not offered until every report predicted so far has come back.
	typedef struct {
		logic [1:0] cmd;
		logic [7:0] ch;
		logic       last;
		bit         hold;
	} char_req_t;

	// One position report, as predicted or as seen on the result channel.
	typedef struct {
		logic [1:0]         status;
		logic               fix;
		logic signed [31:0] lat;
		logic signed [31:0] lon;
		logic [26:0]        speed;
	} report_t;

	logic clk;
	logic arst_n;

	nmeap_char_if   chars();
	nmeap_result_if result();

	nmea_position_sentence_parser #(.LINE_LEN(LINE_LEN)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.result (result)
	);

	char_req_t pending_chars[$];
	report_t   expected_reports[$];
	int        chars_queued;
	int        chars_sent;
	int        reports_queued;
	int        mismatches;
	int        send_gap;
	int        recv_gap;
	int        idle_cycles;

	// ------------------------------------------------------------------------
	// Sentence state of the predictor. The coordinate arrays hold both degree
	// splits of both coordinates: index 2*coord + split, where split 0 reads
	// two degree digits and split 1 reads three.
	// ------------------------------------------------------------------------
	logic [7:0]  pr_count;
	logic [3:0]  pr_fields;
	logic [7:0]  pr_flen;
	logic [31:0] pr_deg[4];
	logic [63:0] pr_min[4];
	logic [3:0]  pr_cphase[4];
	logic [7:0]  pr_clen[2];
	logic [7:0]  pr_hemi[2];
	logic [7:0]  pr_status_ch;
	logic        pr_qual_nz;
	logic [1:0]  pr_qphase;
	logic [63:0] pr_speed;
	logic [2:0]  pr_sphase;
	logic        pr_fix_held;

	function automatic bit is_dig(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic [63:0] dec_weight(int n);
		logic [63:0] w;
		w = 1;
		repeat (n) w = w * 10;
		return w;
	endfunction

	task automatic clear_sentence();
		pr_count = 0;
		pr_fields = 0;
		pr_flen = 0;
		for (int i = 0; i < 4; i++) begin
			pr_deg[i] = 0;
			pr_min[i] = 0;
			pr_cphase[i] = CP_DEG;
		end
		for (int k = 0; k < 2; k++) begin
			pr_clen[k] = 0;
			pr_hemi[k] = 0;
		end
		pr_status_ch = 0;
		pr_qual_nz = 0;
		pr_qphase = QP_LEAD;
		pr_speed = 0;
		pr_sphase = SP_INT;
	endtask

	// Which quantity a field carries, by format and field number.
	function automatic nmeap_role_t field_role(logic [1:0] cmd, int tok);
		case (cmd)
			CMD_RMC: begin
				case (tok)
					2: return ROLE_STATUS;
					3: return ROLE_LAT;
					4: return ROLE_LATH;
					5: return ROLE_LON;
					6: return ROLE_LONH;
					7: return ROLE_SPEED;
					default: return ROLE_NONE;
				endcase
			end
			CMD_GLL: begin
				case (tok)
					1: return ROLE_LAT;
					2: return ROLE_LATH;
					3: return ROLE_LON;
					4: return ROLE_LONH;
					6: return ROLE_STATUS;
					default: return ROLE_NONE;
				endcase
			end
			CMD_GGA: begin
				case (tok)
					2: return ROLE_LAT;
					3: return ROLE_LATH;
					4: return ROLE_LON;
					5: return ROLE_LONH;
					6: return ROLE_QUAL;
					default: return ROLE_NONE;
				endcase
			end
			default: return ROLE_NONE;
		endcase
	endfunction

	// Both degree splits of a coordinate advance on every character, since
	// the hemisphere letter that picks one arrives only afterwards.
	task automatic coord_char(int k, int p, logic [7:0] c);
		int i;
		int dl;
		logic [63:0] v;
		pr_clen[k] = (p + 1 > 255) ? 8'd255 : 8'(p + 1);
		for (int s = 0; s < 2; s++) begin
			i = 2 * k + s;
			dl = 2 + s;
			if (p < dl) begin
				if (pr_cphase[i] == CP_DEG) begin
					if (is_dig(c)) pr_deg[i] = pr_deg[i] * 10 + 32'(c - CH_ZERO);
					else pr_cphase[i] = CP_DEG_END;
				end
				continue;
			end
			if (p == dl) pr_cphase[i] = CP_MIN_INT;
			if (pr_cphase[i] == CP_MIN_INT) begin
				if (is_dig(c)) begin
					v = pr_min[i] * 10 + 64'(c - CH_ZERO) * 100000;
					pr_min[i] = (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
				end else if (c == CH_DOT) begin
					pr_cphase[i] = CP_FRAC1;
				end else begin
					pr_cphase[i] = CP_DONE;
				end
			end else if (pr_cphase[i] >= CP_FRAC1 && pr_cphase[i] <= CP_FRAC5) begin
				if (is_dig(c)) begin
					v = pr_min[i] + 64'(c - CH_ZERO) * dec_weight(4 - (pr_cphase[i] - CP_FRAC1));
					pr_min[i] = (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
					pr_cphase[i] = pr_cphase[i] + 1;
				end else begin
					pr_cphase[i] = CP_DONE;
				end
			end
		end
	endtask

	// Fix quality reads like atoi: blanks, one sign, then digits.
	task automatic quality_char(logic [7:0] c);
		if (pr_qphase == QP_LEAD) begin
			if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
			pr_qphase = QP_DIGIT;
			if (c == CH_PLUS || c == CH_MINUS) return;
		end
		if (pr_qphase == QP_DIGIT) begin
			if (is_dig(c)) begin
				if (c != CH_ZERO) pr_qual_nz = 1;
			end else begin
				pr_qphase = QP_DONE;
			end
		end
	endtask

	task automatic speed_char(logic [7:0] c);
		logic [63:0] v;
		if (pr_sphase == SP_INT) begin
			if (is_dig(c)) begin
				v = pr_speed * 10 + 64'(c - CH_ZERO) * 1000;
				pr_speed = (v > 99999999) ? 64'd99999999 : v;
			end else if (c == CH_DOT) begin
				pr_sphase = SP_FRAC;
			end else begin
				pr_sphase = SP_DONE;
			end
		end else if (pr_sphase < SP_DONE) begin
			if (is_dig(c)) begin
				v = pr_speed + 64'(c - CH_ZERO) * dec_weight(3 - pr_sphase);
				pr_speed = (v > 99999999) ? 64'd99999999 : v;
				pr_sphase = pr_sphase + 1;
			end else begin
				pr_sphase = SP_DONE;
			end
		end
	endtask

	task automatic parse_char(logic [1:0] cmd, logic [7:0] c);
		int p;
		if (pr_count >= LINE_LEN - 1) return;
		// A NUL ends the string: nothing after it up to the last mark counts.
		if (c == CH_NUL) begin
			pr_count = LINE_LEN - 1;
			return;
		end
		pr_count++;
		if (c == CH_COMMA) begin
			pr_flen = 0;
			return;
		end
		if (pr_flen == 0 && pr_fields < FIELD_CAP) pr_fields++;
		p = pr_flen;
		if (pr_flen < LEN_CAP) pr_flen++;
		case (field_role(cmd, int'(pr_fields) - 1))
			ROLE_LAT:    coord_char(0, p, c);
			ROLE_LON:    coord_char(1, p, c);
			ROLE_LATH:   if (p == 0) pr_hemi[0] = c;
			ROLE_LONH:   if (p == 0) pr_hemi[1] = c;
			ROLE_STATUS: if (p == 0) pr_status_ch = c;
			ROLE_QUAL:   quality_char(c);
			ROLE_SPEED:  speed_char(c);
			default: ;
		endcase
	endtask

	// Degrees plus rounded minutes/60 in 1e-7 degree units, saturated, and
	// negated for south and west; zero for a field under four characters.
	function automatic logic [31:0] coord_position(int k);
		int i;
		logic [63:0] mag;
		logic [7:0] h;
		h = pr_hemi[k];
		i = 2 * k + ((h == CH_N || h == CH_S) ? 0 : 1);
		if (pr_clen[k] < 4) return 0;
		mag = 64'(pr_deg[i]) * 10000000 + (pr_min[i] * 5 + 1) / 3;
		if (mag > 2147483647) mag = 2147483647;
		if (h == CH_S || h == CH_W) return 32'(-mag);
		return mag[31:0];
	endfunction

	// Takes one accepted character; on a last character queues its report.
	task automatic predict_char(logic [1:0] cmd, logic [7:0] c, logic last);
		report_t r;
		bit fix;
		parse_char(cmd, c);
		if (!last) return;
		r = '{status: ST_TOO_FEW, fix: 0, lat: 0, lon: 0, speed: 0};
		if (cmd <= CMD_GGA && pr_fields >= MIN_FIELDS) begin
			fix = (cmd == CMD_GGA) ? pr_qual_nz : (pr_status_ch == CH_A);
			if (!fix) begin
				r.status = ST_NO_FIX;
				pr_fix_held = 0;
			end else begin
				r.status = ST_VALID;
				pr_fix_held = 1;
				r.lat = coord_position(0);
				r.lon = coord_position(1);
				if (cmd == CMD_RMC) r.speed = pr_speed[26:0];
			end
		end
		r.fix = pr_fix_held;
		expected_reports.push_back(r);
		clear_sentence();
	endtask

	// ------------------------------------------------------------------------
	// Sentence building.
	// ------------------------------------------------------------------------
	function automatic string digits(int n);
		string s;
		s = "";
		repeat (n) s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
		return s;
	endfunction

	function automatic string pick(string options);
		int i;
		i = $urandom_range(0, options.len() - 1);
		return options.substr(i, i);
	endfunction

	// A coordinate field: mostly degrees, minutes and a fraction of random
	// length, sometimes empty, too short, or large enough to saturate.
	function automatic string coord_text(int deg_digits);
		case ($urandom_range(0, 9))
			0: return "";
			1: return digits($urandom_range(1, 3));
			2: return "99999999999.9999999";
			3: return {digits(deg_digits + 2)};
			default: return {digits(deg_digits + 2), ".", digits($urandom_range(0, 7))};
		endcase
	endfunction

	function automatic string speed_text();
		case ($urandom_range(0, 7))
			0: return "";
			1: return "999999999.999";
			2: return {".", digits($urandom_range(0, 5))};
			default: return {digits($urandom_range(1, 4)), ".", digits($urandom_range(0, 5))};
		endcase
	endfunction

	function automatic string quality_text();
		case ($urandom_range(0, 7))
			0: return "0";
			1: return " 1";
			2: return "+2";
			3: return "-0";
			4: return "00";
			5: return "";
			default: return digits(1);
		endcase
	endfunction

	function automatic string well_formed(logic [1:0] cmd);
		string lat_h;
		string lon_h;
		lat_h = pick("NNNSSEWX");
		lon_h = pick("EEEWWNSX");
		case (cmd)
			CMD_RMC: return {"$GPRMC,", digits(6), ",", pick("AAAAV"), ",", coord_text(2),
				",", lat_h, ",", coord_text(3), ",", lon_h, ",", speed_text(), ",",
				digits(3), ".", digits(1), ",", digits(6), ",,*", digits(2)};
			CMD_GLL: return {"$GPGLL,", coord_text(2), ",", lat_h, ",", coord_text(3), ",",
				lon_h, ",", digits(6), ".00,", pick("AAAAV"), ",A*", digits(2)};
			default: return {"$GPGGA,", digits(6), ",", coord_text(2), ",", lat_h, ",",
				coord_text(3), ",", lon_h, ",", quality_text(), ",", digits(2), ",0.9,",
				digits(3), ",M,46.9,M,,*", digits(2)};
		endcase
	endfunction

	// Queues one sentence. From switch_at on the characters carry switch_cmd.
	task automatic queue_sentence(logic [7:0] text[$], logic [1:0] cmd, bit hold,
		int switch_at, logic [1:0] switch_cmd);
		char_req_t r;
		foreach (text[i]) begin
			r.cmd = (i >= switch_at) ? switch_cmd : cmd;
			r.ch = text[i];
			r.last = (i == text.size() - 1);
			r.hold = hold && i == 0;
			pending_chars.push_back(r);
		end
		chars_queued += text.size();
		reports_queued++;
	endtask

	task automatic queue_text(string s, logic [1:0] cmd);
		logic [7:0] text[$];
		for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
		queue_sentence(text, cmd, 0, s.len(), cmd);
	endtask

	// A random sentence. Most are well formed with random content; the rest
	// get stray bytes, inserted commas, NULs, overlong tails or a format change.
	task automatic queue_random();
		string s;
		logic [7:0] text[$];
		logic [1:0] cmd;
		int switch_at;
		logic [1:0] switch_cmd;
		cmd = 2'($urandom_range(0, 2));
		s = ($urandom_range(0, 9) == 0) ? digits($urandom_range(0, 3)) : well_formed(cmd);
		for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
		if (text.size() == 0) text.push_back(8'($urandom_range(0, 255)));
		switch_at = text.size();
		switch_cmd = cmd;
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 5))
				0: repeat ($urandom_range(1, 3))
					text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
				1: text[$urandom_range(0, text.size() - 1)] = CH_NUL;
				2: repeat ($urandom_range(60, 140)) text.push_back(8'($urandom_range(32, 126)));
				3: cmd = 2'd3;
				4: begin
					switch_at = $urandom_range(0, text.size() - 1);
					switch_cmd = 2'($urandom_range(0, 3));
				end
				default: repeat ($urandom_range(1, 4))
					text.insert($urandom_range(0, text.size()), CH_COMMA);
			endcase
		end
		queue_sentence(text, cmd, $urandom_range(0, 19) == 0, switch_at, switch_cmd);
	endtask

	// ------------------------------------------------------------------------
	// Clock, reset and stimulus.
	// ------------------------------------------------------------------------
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 0;

		// Directed sentences: each format valid, both hemisphere signs, the
		// no-fix cases, too few fields, collapsed empty fields, an unknown
		// format, a NUL, bytes with the top bit set, saturation and an
		// overlong line.
		queue_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A",
			CMD_RMC);
		queue_text("$GPRMC,1,A,0000.00000,S,18000.99999,W,0.001,,,", CMD_RMC);
		queue_text("$GPGLL,4916.45,N,12311.12,W,225444,A,*1D", CMD_GLL);
		queue_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M", CMD_GGA);
		queue_text("$GPGGA,123519,4807.038,N,01131.000,E,0,08,0.9", CMD_GGA);
		queue_text("$GPRMC,123519,V,4807.038,N,01131.000,E,1.5,84", CMD_RMC);
		queue_text("$GPRMC,,A,,1", CMD_RMC);
		queue_text("$GPGLL,,,4916.45,,N,,12311.12,W,,225444,A", CMD_GLL);
		queue_text("$GPGGA,1,2,3,4,5,6,7,8", 2'd3);
		queue_text("$GPRMC,1,A,9959.99999,N,99999999999.99,E,99999999999.9999,x", CMD_RMC);
		queue_text({"$GPRMC,1,A,12", string'(8'hFF), "4.5,S,0,E,1,2,3"}, CMD_RMC);
		begin
			logic [7:0] text[$];
			string s;
			s = "$GPRMC,1,A,4807.038,N,01131.000,E,5,,,";
			for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
			text[20] = CH_NUL;
			queue_sentence(text, CMD_RMC, 1, text.size(), CMD_RMC);
			text.delete();
			s = {"$GPGGA,1,4807.038,N,01131.000,E,1,", digits(120)};
			for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
			text.push_back(8'h80);
			queue_sentence(text, CMD_GGA, 0, text.size(), CMD_GGA);
		end

		while (chars_queued < CHAR_GOAL || reports_queued < 60) queue_random();

		repeat (9) @(posedge clk);
		arst_n <= 1;

		wait (pending_chars.size() == 0 && !chars.valid && expected_reports.size() == 0);
		repeat (30) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_nmea_position_sentence_parser: clean");
		end else begin
			$display("tb_nmea_position_sentence_parser: errors");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// Character driver. The predictor runs here on every accepted request, so
	// a held sentence start sees the report of the sentence just finished.
	// The last part of the run goes without gaps on either side.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars.valid <= 0;
			send_gap <= 0;
			chars_sent <= 0;
			pr_fix_held = 0;
			clear_sentence();
		end else begin
			if (chars.valid && chars.ready) begin
				predict_char(chars.cmd, chars.char_byte, chars.last);
				chars_sent <= chars_sent + 1;
			end
			if (!chars.valid || chars.ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					chars.valid <= 0;
				end else if (chars_sent < chars_queued * 85 / 100
					&& $urandom_range(0, 15) == 0) begin
					send_gap <= $urandom_range(0, 11);
					chars.valid <= 0;
				end else if (pending_chars.size() != 0
					&& !(pending_chars[0].hold && expected_reports.size() != 0)) begin
					chars.cmd <= pending_chars[0].cmd;
					chars.char_byte <= pending_chars[0].ch;
					chars.last <= pending_chars[0].last;
					chars.valid <= 1;
					void'(pending_chars.pop_front());
				end else begin
					chars.valid <= 0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Report receiver: random back-pressure bursts, field-by-field checking.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		report_t want;
		if (!arst_n) begin
			result.ready <= 0;
			recv_gap <= 0;
			mismatches <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_reports.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected report, status %0d", $realtime, result.status);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_reports.pop_front();
					if (result.status !== want.status || result.fix_active !== want.fix
						|| result.latitude !== want.lat || result.longitude !== want.lon
						|| result.speed_milliknots !== want.speed) begin
						if (mismatches < 10)
							$display({"%0t: report mismatch, expected st %0d fix %0d lat %0d",
								" lon %0d spd %0d, got st %0d fix %0d lat %0d lon %0d spd %0d"},
								$realtime, want.status, want.fix, want.lat, want.lon, want.speed,
								result.status, result.fix_active, result.latitude,
								result.longitude, result.speed_milliknots);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (recv_gap != 0) begin
				recv_gap <= recv_gap - 1;
				result.ready <= 0;
			end else if (chars_sent < chars_queued * 85 / 100 && $urandom_range(0, 11) == 0) begin
				recv_gap <= $urandom_range(0, 11);
				result.ready <= 0;
			end else begin
				result.ready <= 1;
			end
		end
	end

	// Watchdog: too long with no request moving on either channel ends the run.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((chars.valid && chars.ready) || (result.valid && result.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_nmea_position_sentence_parser: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
